/* rtl/tcw_pkg.sv */
// Package for the text console writer: field widths, character codes,
// request and result structures and the controller state type.
// No dependencies; used by text_console_writer_core.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int INDEX_W = 11;
    localparam int CELL_W  = 16;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;

    localparam logic [COLOR_W-1:0] COLOR_RESET    = 8'h0F;
    localparam logic [CHAR_W-1:0]  CHAR_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0]  CHAR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0]  CHAR_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE     = 8'h20;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [CHAR_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } request_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic              did_scroll;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_DRAIN,
        ST_FILL
    } state_t;

endpackage

/* rtl/text_console_writer_core.sv */
// Text console writer: screen memory of COLUMNS x ROWS 16-bit cells and a cursor.
// Depends on tcw_pkg for types and constants.
`timescale 1ns / 1ps

// Usage
// A request is taken at a rising edge with start high and busy low. Its
// result appears on result for exactly one cycle with done high; the
// receiver cannot hold it off, so it must sample done every cycle.
// A put of a character, newline, backspace or null byte writes at most one
// cell in the cycle it is taken; unless it scrolls, it gives its result in
// the next cycle and keeps busy low, so such requests can be taken on every
// cycle. A read holds busy high in ST_READ and gives its result through the
// registered read of the screen memory and then the result register.
// A put that moves past the last row scrolls the screen: every cell below
// the top row is copied up one row at one cell per cycle through the single
// read and write ports, and the bottom row is filled with blanks before done.
// After reset the block sweeps the screen memory to zero, one cell a cycle,
// so busy stays high until the last cell is cleared. The colour register may be
// written through cfg_we and cfg_wdata at any time the block is idle.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tcw_pkg::request_t           request,
    output logic                        done,
    output tcw_pkg::result_t            result,
    input  logic                        cfg_we,
    input  logic [tcw_pkg::COLOR_W-1:0] cfg_wdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int WIDE_W     = ADDR_W + tcw_pkg::INDEX_W;
    localparam int COL_W      = tcw_pkg::COL_W;
    localparam int ROW_W      = tcw_pkg::ROW_W;
    localparam int CELL_W     = tcw_pkg::CELL_W;

    tcw_pkg::state_t state_reg, state_next;

    logic [COL_W-1:0]                col_reg, col_next;
    logic [ROW_W-1:0]                row_reg, row_next;
    logic [tcw_pkg::COLOR_W-1:0]     color_reg;
    logic [ADDR_W-1:0]               ptr_reg, ptr_next;
    logic [ADDR_W-1:0]               dst_reg, dst_next;
    logic                            copy_vld_reg, copy_vld_next;
    logic                            hit_reg, hit_next;
    logic                            done_reg, done_next;
    tcw_pkg::result_t                result_reg, result_next;

    logic [CELL_W-1:0] screen_mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic              accept;
    logic              put_active;
    logic              put_we;
    logic [ADDR_W-1:0] put_addr;
    logic [CELL_W-1:0] put_data;
    logic [COL_W:0]    put_col;
    logic [ROW_W:0]    put_row;
    logic              put_scroll;
    logic [WIDE_W-1:0] idx_wide;
    logic              idx_in_range;
    logic [ADDR_W-1:0] cursor_addr;
    logic [CELL_W-1:0] blank_cell;

    assign busy     = (state_reg != tcw_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign done     = done_reg;
    assign result   = result_reg;

    assign idx_wide     = WIDE_W'(request.cell_index);
    assign idx_in_range = (idx_wide < WIDE_W'(CELL_COUNT));
    assign cursor_addr  = ADDR_W'(row_reg * COLUMNS + col_reg);
    assign blank_cell   = {color_reg, tcw_pkg::CHAR_SPACE};

    // Cursor movement, scroll detection and the single cell write, if any, of a put request.
    always_comb
    begin
        put_active = accept && (request.operation == tcw_pkg::OP_PUT)
                     && (request.char_code != tcw_pkg::CHAR_NUL);
        put_we     = 1'b0;
        put_addr   = cursor_addr;
        put_data   = {color_reg, request.char_code};
        put_col    = {1'b0, col_reg};
        put_row    = {1'b0, row_reg};
        put_scroll = 1'b0;

        case (request.char_code)
            tcw_pkg::CHAR_NEWLINE:
            begin
                put_col = '0;
                put_row = put_row + 1'b1;
            end
            tcw_pkg::CHAR_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    put_col  = put_col - 1'b1;
                    put_we   = 1'b1;
                    put_addr = cursor_addr - 1'b1;
                    put_data = blank_cell;
                end
            end
            default:
            begin
                put_we  = 1'b1;
                put_col = put_col + 1'b1;
            end
        endcase

        if (put_col >= (COL_W + 1)'(COLUMNS))
        begin
            put_col = '0;
            put_row = put_row + 1'b1;
        end
        if (put_row >= (ROW_W + 1)'(ROWS))
        begin
            put_row    = (ROW_W + 1)'(ROWS - 1);
            put_scroll = 1'b1;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_CLEAR:
            begin
                if (ptr_reg == ADDR_W'(CELL_COUNT - 1))
                    state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_IDLE:
            begin
                if (accept && (request.operation == tcw_pkg::OP_READ))
                    state_next = tcw_pkg::ST_READ;
                else if (put_active && put_scroll)
                    state_next = tcw_pkg::ST_COPY;
            end
            tcw_pkg::ST_READ:
                state_next = tcw_pkg::ST_IDLE;
            tcw_pkg::ST_COPY:
            begin
                if (ptr_reg == ADDR_W'(CELL_COUNT - 1))
                    state_next = tcw_pkg::ST_DRAIN;
            end
            tcw_pkg::ST_DRAIN:
                state_next = tcw_pkg::ST_FILL;
            tcw_pkg::ST_FILL:
            begin
                if (ptr_reg == ADDR_W'(CELL_COUNT - 1))
                    state_next = tcw_pkg::ST_IDLE;
            end
            default:
                state_next = tcw_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory port control for each state.
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        ptr_next      = ptr_reg;
        dst_next      = dst_reg;
        copy_vld_next = 1'b0;
        hit_next      = hit_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        mem_we        = 1'b0;
        mem_waddr     = ptr_reg;
        mem_wdata     = blank_cell;
        mem_raddr     = ptr_reg;

        case (state_reg)
            tcw_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                ptr_next  = ptr_reg + 1'b1;
            end
            tcw_pkg::ST_IDLE:
            begin
                mem_raddr = idx_wide[ADDR_W-1:0];
                if (accept && (request.operation == tcw_pkg::OP_READ))
                begin
                    hit_next = idx_in_range;
                end
                else if (accept)
                begin
                    if (put_active)
                    begin
                        mem_we    = put_we;
                        mem_waddr = put_addr;
                        mem_wdata = put_data;
                        col_next  = put_col[COL_W-1:0];
                        row_next  = put_row[ROW_W-1:0];
                    end
                    // The scroll copy reads from the second row onwards.
                    ptr_next = ADDR_W'(COLUMNS);
                    result_next.cell_data     = '0;
                    result_next.cursor_column = put_active ? put_col[COL_W-1:0] : col_reg;
                    result_next.cursor_row    = put_active ? put_row[ROW_W-1:0] : row_reg;
                    result_next.did_scroll    = put_active && put_scroll;
                    done_next = !(put_active && put_scroll);
                end
            end
            tcw_pkg::ST_READ:
            begin
                result_next.cell_data     = hit_reg ? rd_data_reg : '0;
                result_next.cursor_column = col_reg;
                result_next.cursor_row    = row_reg;
                result_next.did_scroll    = 1'b0;
                done_next = 1'b1;
            end
            tcw_pkg::ST_COPY:
            begin
                // Read one row below, write the cell read in the previous cycle.
                mem_raddr     = ptr_reg;
                copy_vld_next = 1'b1;
                dst_next      = ptr_reg - ADDR_W'(COLUMNS);
                mem_we        = copy_vld_reg;
                mem_waddr     = dst_reg;
                mem_wdata     = rd_data_reg;
                if (ptr_reg == ADDR_W'(CELL_COUNT - 1))
                    ptr_next = ADDR_W'((ROWS - 1) * COLUMNS);
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            tcw_pkg::ST_DRAIN:
            begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg;
                mem_wdata = rd_data_reg;
            end
            tcw_pkg::ST_FILL:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    done_next = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= screen_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tcw_pkg::ST_CLEAR;
            col_reg      <= '0;
            row_reg      <= '0;
            color_reg    <= tcw_pkg::COLOR_RESET;
            ptr_reg      <= '0;
            copy_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            ptr_reg      <= ptr_next;
            copy_vld_reg <= copy_vld_next;
            done_reg     <= done_next;
            if (cfg_we)
                color_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg    <= dst_next;
        hit_reg    <= hit_next;
        result_reg <= result_next;
    end

endmodule
